FILE: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES_DEF    = 65536;
    localparam int HEADER_BYTES_DEF  = 8;
    localparam int GRANULE_BYTES_DEF = 8;

    localparam int REQ_W      = 17;
    localparam int ADDR_OUT_W = 16;
    localparam int ALIGN_W    = 3;
    localparam int ALIGN_MIN  = 3;
    localparam int ALIGN_MAX  = 6;
    localparam int ALIGN_MAXB = 64;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_SIZE = 2'd2
    } status_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

FILE: rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing free list.
// s_ channel: one request per transfer. s_tuser is the action (0 allocate,
// 1 free); s_tdata carries req_size and free_address. m_ channel: exactly one
// result per request, result_address and status (0 ok, 1 no fit, 2 bad size).
// cfg channel: writes align_log2 (always ready); change it only while idle.
// Free-block records (size, next link) live in one RAM and allocation records
// (live, start, size, adjustment) in another, one entry per granule, both with
// a registered read. Each visited free-list block takes an address step, then
// an evaluate step. Allocate walks the list to the first block that fits; a
// bad size or an empty list is answered without a RAM read. Free walks past
// the free blocks below the freed one; an unknown address is answered without
// a walk. One request is in flight at a time; s_tready is high only while idle.
// Reset: the whole heap is one free block at address 0, align_log2 = 3; no
// clearing pass, s_tready is high as soon as reset is released.
// A stalled m_ side holds the finished result; the next request can still be
// worked on and waits for the output register before it is delivered.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
    parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [16:0] req_size, [32:17] free_address
    input  logic                s_tuser,   // [0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] result_address, [17:16] status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ALIGN_W-1:0]  cfg_data
);

    localparam int GLOG        = $clog2(GRANULE_BYTES);
    localparam int GRANULES    = HEAP_BYTES / GRANULE_BYTES;
    localparam int GIW         = $clog2(GRANULES);
    localparam int HEAP_USABLE = GRANULES * GRANULE_BYTES;
    localparam int AW          = $clog2(HEAP_BYTES + 1);
    localparam int TW          = ((AW > REQ_W) ? AW : REQ_W) + 1;
    localparam int AJW         = $clog2(HEADER_BYTES + ALIGN_MAXB);

    typedef struct packed {
        logic          nv;
        logic [AW-1:0] next;
        logic [AW-1:0] size;
    } frec_t;

    typedef struct packed {
        logic           live;
        logic [AW-1:0]  start;
        logic [AW-1:0]  size;
        logic [AJW-1:0] adj;
    } arec_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_A_WAIT  = 13'b0000000000010,
        S_A_EVAL  = 13'b0000000000100,
        S_A_LINK  = 13'b0000000001000,
        S_F_WAIT  = 13'b0000000010000,
        S_F_CHK   = 13'b0000000100000,
        S_F_WRD   = 13'b0000001000000,
        S_F_WALK  = 13'b0000010000000,
        S_F_INS   = 13'b0000100000000,
        S_F_LINK  = 13'b0001000000000,
        S_F_NX    = 13'b0010000000000,
        S_F_MERGE = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    function automatic logic [GIW-1:0] gidx(input logic [AW-1:0] addr);
        logic [AW-1:0] sh;
        sh = addr >> GLOG;
        return sh[GIW-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic                head_v_reg, head_v_next;
    logic                e0_reg, e0_next;
    logic [ALIGN_W-1:0]  align_reg, align_next;
    logic                act_reg, act_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [AW-1:0]       fa_reg, fa_next;
    logic [AW-1:0]       p_reg, p_next;
    logic                cv_reg, cv_next;
    logic                pv_reg, pv_next;
    logic [AW-1:0]       prev_reg, prev_next;
    logic [AW-1:0]       prev_size_reg, prev_size_next;
    logic [AW-1:0]       prev_link_reg, prev_link_next;
    logic                prev_nv_reg, prev_nv_next;
    logic [AW-1:0]       start_reg, start_next;
    logic [AW-1:0]       bsize_reg, bsize_next;
    logic [AW-1:0]       bend_reg, bend_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       cur_size_reg, cur_size_next;
    logic [AJW-1:0]      adj_reg, adj_next;
    logic [AW-1:0]       total_reg, total_next;
    logic [AW-1:0]       link_reg, link_next;
    logic                link_v_reg, link_v_next;
    logic [ADDR_OUT_W-1:0] pend_addr_reg, pend_addr_next;
    status_t             pend_status_reg, pend_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [ADDR_OUT_W-1:0] out_addr_reg, out_addr_next;
    status_t             out_status_reg, out_status_next;

    logic                fm_we, am_we;
    logic [GIW-1:0]      fm_waddr, am_waddr;
    frec_t               fm_wdata, fm_rdata, frd;
    arec_t               am_wdata, am_rdata;

    logic [ALIGN_W-1:0]  alog;
    logic [6:0]          abytes, amask, ph;
    logic [AJW-1:0]      adj;
    logic [TW-1:0]       tot_raw, total, size_ext, rem;
    logic [AW-1:0]       q_addr, fa_in, aligned;
    logic                fa_ok;

    ffha_ram #(.WIDTH($bits(frec_t)), .DEPTH(GRANULES)) u_free_ram (
        .aclk  (aclk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (gidx(p_reg)),
        .rdata (fm_rdata)
    );

    ffha_ram #(.WIDTH($bits(arec_t)), .DEPTH(GRANULES)) u_alloc_ram (
        .aclk  (aclk),
        .we    (am_we),
        .waddr (am_waddr),
        .wdata (am_wdata),
        .raddr (gidx(fa_reg)),
        .rdata (am_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - ADDR_OUT_W - 2){1'b0}}, out_status_reg, out_addr_reg};

    always_comb begin
        frd = fm_rdata;
        if (gidx(p_reg) == '0 && !e0_reg) begin
            frd.size = AW'(HEAP_USABLE);
            frd.next = '0;
            frd.nv   = 1'b0;
        end
    end

    always_comb begin
        if (align_reg < ALIGN_W'(ALIGN_MIN)) begin
            alog = ALIGN_W'(ALIGN_MIN);
        end else if (align_reg > ALIGN_W'(ALIGN_MAX)) begin
            alog = ALIGN_W'(ALIGN_MAX);
        end else begin
            alog = align_reg;
        end
        abytes   = 7'd1 << alog;
        amask    = abytes - 7'd1;
        ph       = p_reg[6:0] + 7'(HEADER_BYTES);
        adj      = AJW'(HEADER_BYTES) + AJW'((abytes - (ph & amask)) & amask);
        tot_raw  = TW'(req_reg) + TW'(adj) + TW'(GRANULE_BYTES - 1);
        total    = tot_raw & ~TW'(GRANULE_BYTES - 1);
        size_ext = TW'(frd.size);
        rem      = size_ext - total;
        q_addr   = p_reg + AW'(total);
        aligned  = p_reg + AW'(adj_reg);
        fa_in    = AW'(s_tdata[32:17]);
        fa_ok    = (32'(gidx(fa_in)) < 32'(GRANULES)) && (32'(fa_in) < 32'(HEAP_USABLE));
    end

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        head_v_next      = head_v_reg;
        e0_next          = e0_reg;
        align_next       = align_reg;
        act_next         = act_reg;
        req_next         = req_reg;
        fa_next          = fa_reg;
        p_next           = p_reg;
        cv_next          = cv_reg;
        pv_next          = pv_reg;
        prev_next        = prev_reg;
        prev_size_next   = prev_size_reg;
        prev_link_next   = prev_link_reg;
        prev_nv_next     = prev_nv_reg;
        start_next       = start_reg;
        bsize_next       = bsize_reg;
        bend_next        = bend_reg;
        cur_next         = cur_reg;
        cur_size_next    = cur_size_reg;
        adj_next         = adj_reg;
        total_next       = total_reg;
        link_next        = link_reg;
        link_v_next      = link_v_reg;
        pend_addr_next   = pend_addr_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        fm_we            = 1'b0;
        fm_waddr         = '0;
        fm_wdata         = '0;
        am_we            = 1'b0;
        am_waddr         = '0;
        am_wdata         = '0;

        if (cfg_valid) begin
            align_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next         = s_tuser;
                    req_next         = s_tdata[REQ_W-1:0];
                    fa_next          = fa_in;
                    pend_addr_next   = '0;
                    pend_status_next = ST_OK;
                    p_next           = head_reg;
                    cv_next          = head_v_reg;
                    pv_next          = 1'b0;
                    if (s_tuser == ACT_ALLOC) begin
                        if (s_tdata[REQ_W-1:0] == '0 ||
                            32'(s_tdata[REQ_W-1:0]) > 32'(HEAP_BYTES)) begin
                            pend_status_next = ST_BAD_SIZE;
                            state_next       = S_DONE;
                        end else if (!head_v_reg) begin
                            pend_status_next = ST_NO_FIT;
                            state_next       = S_DONE;
                        end else begin
                            state_next = S_A_WAIT;
                        end
                    end else begin
                        state_next = fa_ok ? S_F_WAIT : S_DONE;
                    end
                end
            end
            S_A_WAIT: begin
                state_next = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (size_ext < total) begin
                    pv_next        = 1'b1;
                    prev_next      = p_reg;
                    prev_size_next = frd.size;
                    p_next         = frd.next;
                    if (!frd.nv) begin
                        pend_status_next = ST_NO_FIT;
                        state_next       = S_DONE;
                    end else begin
                        state_next = S_A_WAIT;
                    end
                end else begin
                    adj_next = adj;
                    if (rem <= TW'(HEADER_BYTES)) begin
                        total_next  = frd.size;
                        link_next   = frd.next;
                        link_v_next = frd.nv;
                    end else begin
                        total_next    = AW'(total);
                        link_next     = q_addr;
                        link_v_next   = 1'b1;
                        fm_we         = 1'b1;
                        fm_waddr      = gidx(q_addr);
                        fm_wdata.size = AW'(rem);
                        fm_wdata.next = frd.next;
                        fm_wdata.nv   = frd.nv;
                    end
                    state_next = S_A_LINK;
                end
            end
            S_A_LINK: begin
                if (pv_reg) begin
                    fm_we         = 1'b1;
                    fm_waddr      = gidx(prev_reg);
                    fm_wdata.size = prev_size_reg;
                    fm_wdata.next = link_reg;
                    fm_wdata.nv   = link_v_reg;
                end else begin
                    head_next   = link_reg;
                    head_v_next = link_v_reg;
                end
                am_we            = 1'b1;
                am_waddr         = gidx(aligned);
                am_wdata.live    = 1'b1;
                am_wdata.start   = p_reg;
                am_wdata.size    = total_reg;
                am_wdata.adj     = adj_reg;
                pend_addr_next   = aligned[ADDR_OUT_W-1:0];
                pend_status_next = ST_OK;
                state_next       = S_DONE;
            end
            S_F_WAIT: begin
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (am_rdata.live && fa_reg >= am_rdata.start &&
                    (fa_reg - am_rdata.start) == AW'(am_rdata.adj)) begin
                    am_we         = 1'b1;
                    am_waddr      = gidx(fa_reg);
                    am_wdata      = am_rdata;
                    am_wdata.live = 1'b0;
                    start_next    = am_rdata.start;
                    bsize_next    = am_rdata.size;
                    bend_next     = am_rdata.start + am_rdata.size;
                    state_next    = S_F_WRD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_F_WRD: begin
                state_next = (!cv_reg || p_reg >= bend_reg) ? S_F_INS : S_F_WALK;
            end
            S_F_WALK: begin
                pv_next        = 1'b1;
                prev_next      = p_reg;
                prev_size_next = frd.size;
                prev_link_next = frd.next;
                prev_nv_next   = frd.nv;
                cv_next        = frd.nv;
                p_next         = frd.next;
                state_next     = S_F_WRD;
            end
            S_F_INS: begin
                fm_we = 1'b1;
                if (!pv_reg) begin
                    fm_waddr      = gidx(start_reg);
                    fm_wdata.size = bsize_reg;
                    fm_wdata.next = head_reg;
                    fm_wdata.nv   = head_v_reg;
                    head_next     = start_reg;
                    head_v_next   = 1'b1;
                    cur_next      = start_reg;
                    cur_size_next = bsize_reg;
                    state_next    = S_F_NX;
                end else if (prev_reg + prev_size_reg == start_reg) begin
                    fm_waddr      = gidx(prev_reg);
                    fm_wdata.size = prev_size_reg + bsize_reg;
                    fm_wdata.next = prev_link_reg;
                    fm_wdata.nv   = prev_nv_reg;
                    cur_next      = prev_reg;
                    cur_size_next = prev_size_reg + bsize_reg;
                    state_next    = S_F_NX;
                end else begin
                    fm_waddr      = gidx(start_reg);
                    fm_wdata.size = bsize_reg;
                    fm_wdata.next = prev_link_reg;
                    fm_wdata.nv   = prev_nv_reg;
                    cur_next      = start_reg;
                    cur_size_next = bsize_reg;
                    state_next    = S_F_LINK;
                end
            end
            S_F_LINK: begin
                fm_we         = 1'b1;
                fm_waddr      = gidx(prev_reg);
                fm_wdata.size = prev_size_reg;
                fm_wdata.next = start_reg;
                fm_wdata.nv   = 1'b1;
                state_next    = S_F_NX;
            end
            S_F_NX: begin
                state_next = (cv_reg && p_reg == bend_reg) ? S_F_MERGE : S_DONE;
            end
            S_F_MERGE: begin
                fm_we         = 1'b1;
                fm_waddr      = gidx(cur_reg);
                fm_wdata.size = cur_size_reg + frd.size;
                fm_wdata.next = frd.next;
                fm_wdata.nv   = frd.nv;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_addr_next   = pend_addr_reg;
                    out_status_next = pend_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fm_we && fm_waddr == '0) begin
            e0_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            head_v_reg  <= 1'b1;
            e0_reg      <= 1'b0;
            align_reg   <= ALIGN_W'(ALIGN_MIN);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            head_v_reg  <= head_v_next;
            e0_reg      <= e0_next;
            align_reg   <= align_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        req_reg         <= req_next;
        fa_reg          <= fa_next;
        p_reg           <= p_next;
        cv_reg          <= cv_next;
        pv_reg          <= pv_next;
        prev_reg        <= prev_next;
        prev_size_reg   <= prev_size_next;
        prev_link_reg   <= prev_link_next;
        prev_nv_reg     <= prev_nv_next;
        start_reg       <= start_next;
        bsize_reg       <= bsize_next;
        bend_reg        <= bend_next;
        cur_reg         <= cur_next;
        cur_size_reg    <= cur_size_next;
        adj_reg         <= adj_next;
        total_reg       <= total_next;
        link_reg        <= link_next;
        link_v_reg      <= link_v_next;
        pend_addr_reg   <= pend_addr_next;
        pend_status_reg <= pend_status_next;
        out_addr_reg    <= out_addr_next;
        out_status_reg  <= out_status_next;
    end

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!fm_we && !am_we))
        else $error("RAM write while idle");

    a_free_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && act_reg == ACT_FREE) |-> (pend_status_reg == ST_OK))
        else $error("free answered with non-ok status");

    a_head_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_F_INS && !pv_reg) |=> head_v_reg)
        else $error("free list head not valid after insert at head");

    a_alloc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_A_LINK) |=> (state_reg == S_DONE && pend_status_reg == ST_OK))
        else $error("granted allocation not reported ok");

endmodule
